[hw/rtl/tshb_pkg.sv]
// Shared types and constants for the timestamped history buffer.
package tshb_pkg;

  localparam int DEF_BUFFERS      = 4;
  localparam int DEF_DEPTH        = 1024;
  localparam int DEF_PAYLOAD_BITS = 64;

  localparam int STAMP_W = 32;
  localparam int PAY_W   = 64;
  localparam int OP_W    = 2;
  localparam int SEL_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_APP_RD,
    ST_APP_CMP,
    ST_APP_WR,
    ST_LK_FRD,
    ST_LK_FCMP,
    ST_LK_BRD,
    ST_LK_BCMP,
    ST_LK_PRD,
    ST_LK_PCAP,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic               ok;
    logic               not_ended;
    logic [PAY_W-1:0]   payload_out;
    logic [STAMP_W-1:0] last_stamp;
  } result_t;

endpackage

[hw/rtl/tshb_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tshb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/tshb_out_stage.sv]
// Output register between the sequencer and the result channel.
module tshb_out_stage
  import tshb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  result_t             res,
  output logic                res_ready,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_ok,
  output logic                out_not_ended,
  output logic [PAY_W-1:0]    out_payload_out,
  output logic [STAMP_W-1:0]  out_last_stamp
);

  logic    out_valid_r;
  result_t hold_r;

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      hold_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = hold_r.ok;
  assign out_not_ended   = hold_r.not_ended;
  assign out_payload_out = hold_r.payload_out;
  assign out_last_stamp  = hold_r.last_stamp;

endmodule

[hw/rtl/tshb_ctrl.sv]
// Sequencer: per-buffer fill/cursor state and the walks over the frame memories.
module tshb_ctrl
  import tshb_pkg::*;
#(
  parameter int BUFFERS      = DEF_BUFFERS,
  parameter int DEPTH        = DEF_DEPTH,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [OP_W-1:0]        in_op,
  input  logic [SEL_W-1:0]       in_buffer_sel,
  input  logic [STAMP_W-1:0]     in_stamp,
  input  logic [PAY_W-1:0]       in_payload_in,
  output logic                   res_valid,
  output result_t                res,
  input  logic                   res_ready
);

  localparam int BW      = (BUFFERS > 1) ? $clog2(BUFFERS) : 1;
  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int WW      = CW + 1;
  localparam int MEM_AW  = BW + AW;
  localparam int MEM_DEP = 1 << MEM_AW;

  state_t state_r, state_nxt;

  op_t                     op_r, op_nxt;
  logic [BW-1:0]           sel_r, sel_nxt;
  logic                    sel_ok_r, sel_ok_nxt;
  logic [STAMP_W-1:0]      stamp_r, stamp_nxt;
  logic [PAYLOAD_BITS-1:0] pay_r, pay_nxt;
  logic [CW-1:0]           n_r, n_nxt;
  logic [AW-1:0]           ic_r, ic_nxt;
  logic                    ok_r, ok_nxt;
  logic                    ne_r, ne_nxt;
  logic [PAY_W-1:0]        pout_r, pout_nxt;

  logic [CW-1:0]      fill_r [BUFFERS];
  logic [CW-1:0]      fill_nxt [BUFFERS];
  logic [AW-1:0]      cur_r [BUFFERS];
  logic [AW-1:0]      cur_nxt [BUFFERS];
  logic [STAMP_W-1:0] last_r [BUFFERS];
  logic [STAMP_W-1:0] last_nxt [BUFFERS];

  logic                    mem_we;
  logic [AW-1:0]           rd_idx;
  logic [MEM_AW-1:0]       waddr, raddr;
  logic [STAMP_W-1:0]      st_rdata;
  logic [PAYLOAD_BITS-1:0] pl_rdata;

  logic [CW-1:0]      fill_sel;
  logic [AW-1:0]      cur_sel;
  logic [STAMP_W-1:0] last_sel;
  logic [AW-1:0]      ic_clamp;
  logic               app_trunc;
  logic               fwd_more;
  logic               room;
  logic               accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  assign fill_sel = fill_r[sel_r];
  assign cur_sel  = cur_r[sel_r];
  assign last_sel = last_r[sel_r];

  // Cursor clamped to the last stored entry (zero when empty).
  always_comb begin
    ic_clamp = cur_sel;
    if (fill_sel == '0) begin
      ic_clamp = '0;
    end else if (WW'(cur_sel) >= WW'(fill_sel)) begin
      ic_clamp = AW'(fill_sel - CW'(1));
    end
  end

  // Last stored stamp already tells whether the first trailing frame goes.
  assign app_trunc = (fill_sel != '0) && (last_sel >= stamp_r);
  assign fwd_more  = (WW'(ic_r) + WW'(2)) < WW'(n_r);
  assign room      = n_r < CW'(DEPTH);

  assign waddr = {sel_r, n_r[AW-1:0]};
  assign raddr = {sel_r, rd_idx};

  tshb_ram #(.WIDTH(STAMP_W), .DEPTH(MEM_DEP)) u_stamp_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (stamp_r),
    .raddr (raddr),
    .rdata (st_rdata)
  );

  tshb_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(MEM_DEP)) u_payload_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (pay_r),
    .raddr (raddr),
    .rdata (pl_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (op_r == OP_CLEAR || !sel_ok_r) begin
          state_nxt = ST_RESP;
        end else begin
          case (op_r)
            OP_APPEND: state_nxt = app_trunc ? ST_APP_RD : ST_APP_WR;
            OP_LOOKUP: state_nxt = (fill_sel >= CW'(2)) ? ST_LK_FRD : ST_RESP;
            default:   state_nxt = ST_RESP;
          endcase
        end
      end
      ST_APP_RD:  state_nxt = (n_r == '0) ? ST_APP_WR : ST_APP_CMP;
      ST_APP_CMP: state_nxt = (st_rdata >= stamp_r) ? ST_APP_RD : ST_APP_WR;
      ST_APP_WR:  state_nxt = ST_RESP;
      ST_LK_FRD:  state_nxt = fwd_more ? ST_LK_FCMP : ST_LK_BRD;
      ST_LK_FCMP: state_nxt = (st_rdata <= stamp_r) ? ST_LK_FRD : ST_LK_BRD;
      ST_LK_BRD:  state_nxt = (ic_r == '0) ? ST_LK_PRD : ST_LK_BCMP;
      ST_LK_BCMP: state_nxt = (st_rdata > stamp_r) ? ST_LK_BRD : ST_LK_PRD;
      ST_LK_PRD:  state_nxt = ST_LK_PCAP;
      ST_LK_PCAP: state_nxt = ST_RESP;
      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory controls and per-buffer state
  always_comb begin
    op_nxt     = op_r;
    sel_nxt    = sel_r;
    sel_ok_nxt = sel_ok_r;
    stamp_nxt  = stamp_r;
    pay_nxt    = pay_r;
    n_nxt      = n_r;
    ic_nxt     = ic_r;
    ok_nxt     = ok_r;
    ne_nxt     = ne_r;
    pout_nxt   = pout_r;
    fill_nxt   = fill_r;
    cur_nxt    = cur_r;
    last_nxt   = last_r;
    mem_we     = 1'b0;
    rd_idx     = ic_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt     = op_t'(in_op);
          sel_nxt    = BW'(in_buffer_sel);
          sel_ok_nxt = (32'(in_buffer_sel) < BUFFERS);
          stamp_nxt  = in_stamp;
          pay_nxt    = in_payload_in[PAYLOAD_BITS-1:0];
        end
      end
      ST_DISPATCH: begin
        ok_nxt   = 1'b0;
        ne_nxt   = 1'b0;
        pout_nxt = '0;
        n_nxt    = fill_sel;
        ic_nxt   = ic_clamp;
        if (op_r == OP_CLEAR) begin
          ok_nxt = 1'b1;
          for (int i = 0; i < BUFFERS; i++) begin
            fill_nxt[i] = '0;
            cur_nxt[i]  = '0;
          end
        end else if (sel_ok_r) begin
          if (op_r == OP_APPEND && app_trunc) begin
            n_nxt = fill_sel - CW'(1);
          end
          if (op_r == OP_LOOKUP && fill_sel < CW'(2)) begin
            cur_nxt[sel_r] = ic_clamp;
          end
        end
      end
      ST_APP_RD: begin
        rd_idx = AW'(n_r - CW'(1));
      end
      ST_APP_CMP: begin
        if (st_rdata >= stamp_r) begin
          n_nxt = n_r - CW'(1);
        end
      end
      ST_APP_WR: begin
        if (room) begin
          mem_we          = 1'b1;
          fill_nxt[sel_r] = n_r + CW'(1);
          last_nxt[sel_r] = stamp_r;
          ok_nxt          = 1'b1;
        end else begin
          fill_nxt[sel_r] = n_r;
        end
      end
      ST_LK_FRD: begin
        rd_idx = ic_r + AW'(1);
      end
      ST_LK_FCMP: begin
        if (st_rdata <= stamp_r) begin
          ic_nxt = ic_r + AW'(1);
        end
      end
      ST_LK_BRD: begin
        rd_idx = ic_r;
      end
      ST_LK_BCMP: begin
        if (st_rdata > stamp_r) begin
          ic_nxt = ic_r - AW'(1);
        end
      end
      ST_LK_PRD: begin
        rd_idx         = ic_r;
        cur_nxt[sel_r] = ic_r;
      end
      ST_LK_PCAP: begin
        ok_nxt   = 1'b1;
        ne_nxt   = (stamp_r <= last_sel);
        pout_nxt = PAY_W'(pl_rdata);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_valid       = (state_r == ST_RESP);
    res.ok          = ok_r;
    res.not_ended   = ne_r;
    res.payload_out = pout_r;
    res.last_stamp  = '0;
    if (sel_ok_r && op_r != OP_CLEAR && fill_sel != '0) begin
      res.last_stamp = last_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < BUFFERS; i++) begin
        fill_r[i] <= '0;
        cur_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      cur_r   <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    sel_r    <= sel_nxt;
    sel_ok_r <= sel_ok_nxt;
    stamp_r  <= stamp_nxt;
    pay_r    <= pay_nxt;
    n_r      <= n_nxt;
    ic_r     <= ic_nxt;
    ok_r     <= ok_nxt;
    ne_r     <= ne_nxt;
    pout_r   <= pout_nxt;
    last_r   <= last_nxt;
  end

endmodule

[hw/rtl/timestamped_history_buffer.sv]
// Top level of the timestamped history buffer.
//
// Input channel (in_valid/in_stall) carries one operation per transaction:
// append a frame, look up by time, or clear all buffers. Each transaction
// yields exactly one result transaction on out_valid/out_stall.
// Frames live in two RAMs (stamp and payload), one write and one read port
// each, with registered read data; fill counts, cursors and last stamps
// sit in flops.
// Clear, bad buffer, unused op and short lookups go straight from dispatch
// to the result; an append first walks back over the frames it drops, and
// a lookup on two or more frames walks the cursor forward, then back, and
// then reads the payload.
// Each step costs one RAM read and one compare, which sets the rate.
// One transaction is in flight at a time; in_stall is high until the result
// moves into the output register, so a new item can be taken while the
// previous result still waits on out_stall.
// Reset empties all buffers and zeroes cursors; memory contents need no
// clearing pass. A stalled result holds steady on the out_ ports.
module timestamped_history_buffer
  import tshb_pkg::*;
#(
  parameter int BUFFERS      = DEF_BUFFERS,
  parameter int DEPTH        = DEF_DEPTH,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_op,
  input  logic [SEL_W-1:0]   in_buffer_sel,
  input  logic [STAMP_W-1:0] in_stamp,
  input  logic [PAY_W-1:0]   in_payload_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic               out_not_ended,
  output logic [PAY_W-1:0]   out_payload_out,
  output logic [STAMP_W-1:0] out_last_stamp
);

  logic    res_valid;
  logic    res_ready;
  result_t res;

  tshb_ctrl #(
    .BUFFERS      (BUFFERS),
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_buffer_sel (in_buffer_sel),
    .in_stamp      (in_stamp),
    .in_payload_in (in_payload_in),
    .res_valid     (res_valid),
    .res           (res),
    .res_ready     (res_ready)
  );

  tshb_out_stage u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res             (res),
    .res_ready       (res_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_not_ended   (out_not_ended),
    .out_payload_out (out_payload_out),
    .out_last_stamp  (out_last_stamp)
  );

endmodule

[bench/timestamped_history_buffer_tb.sv]
// Self-checking testbench for the timestamped history buffer.
module timestamped_history_buffer_tb
  import tshb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUFFERS     = DEF_BUFFERS;
  localparam int DEPTH       = DEF_DEPTH;
  localparam int IDLE_PCT    = 37;
  localparam int TAIL_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT_CYCLES = 4_000_000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    in_op = OP_APPEND;
  logic [SEL_W-1:0]   in_buffer_sel = '0;
  logic [STAMP_W-1:0] in_stamp = '0;
  logic [PAY_W-1:0]   in_payload_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_ok;
  logic               out_not_ended;
  logic [PAY_W-1:0]   out_payload_out;
  logic [STAMP_W-1:0] out_last_stamp;

  timestamped_history_buffer u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_buffer_sel   (in_buffer_sel),
    .in_stamp        (in_stamp),
    .in_payload_in   (in_payload_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ok          (out_ok),
    .out_not_ended   (out_not_ended),
    .out_payload_out (out_payload_out),
    .out_last_stamp  (out_last_stamp)
  );

  always #5 clk = ~clk;

  // Shadow copy of the frame history
  logic [STAMP_W-1:0] stamp_mem [BUFFERS][DEPTH];
  logic [PAY_W-1:0]   frame_mem [BUFFERS][DEPTH];
  int unsigned        frames_held [BUFFERS];
  int unsigned        walk_pos [BUFFERS];

  result_t     pending_results [$];
  result_t     want;
  int          err_count = 0;
  int          cycle_count = 0;
  int          hold_cycles = 0;
  bit          src_idle_en = 1'b1;
  bit          sink_idle_en = 1'b1;

  initial begin
    foreach (frames_held[i]) begin
      frames_held[i] = 0;
      walk_pos[i] = 0;
    end
  end

  function automatic result_t predict_history_op(input logic [OP_W-1:0] op,
                                                 input int unsigned b,
                                                 input logic [STAMP_W-1:0] t,
                                                 input logic [PAY_W-1:0] pay);
    result_t     r;
    int unsigned n;
    int unsigned ic;
    r = '0;
    n = frames_held[b];
    case (op)
      OP_CLEAR: begin
        foreach (frames_held[i]) begin
          frames_held[i] = 0;
          walk_pos[i] = 0;
        end
        r.ok = 1'b1;
        return r;
      end
      OP_APPEND: begin
        // newer-or-equal trailing frames are superseded
        while (n > 0 && stamp_mem[b][n-1] >= t) n--;
        if (n < DEPTH) begin
          stamp_mem[b][n] = t;
          frame_mem[b][n] = pay;
          n++;
          r.ok = 1'b1;
        end
        frames_held[b] = n;
      end
      OP_LOOKUP: begin
        ic = walk_pos[b];
        if (n == 0) ic = 0;
        else if (ic > n - 1) ic = n - 1;
        if (n >= 2) begin
          while (ic + 1 < n - 1 && stamp_mem[b][ic+1] <= t) ic++;
          while (ic > 0 && stamp_mem[b][ic] > t) ic--;
          r.ok = 1'b1;
          r.payload_out = frame_mem[b][ic];
          r.not_ended = (t <= stamp_mem[b][n-1]);
        end
        walk_pos[b] = ic;
      end
      default: ;
    endcase
    r.last_stamp = (frames_held[b] > 0) ? stamp_mem[b][frames_held[b]-1] : '0;
    return r;
  endfunction

  task automatic issue_op(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
                          input logic [STAMP_W-1:0] t, input logic [PAY_W-1:0] pay);
    result_t pred;
    while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_buffer_sel <= sel;
    in_stamp      <= t;
    in_payload_in <= pay;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_history_op(op, sel, t, pay);
    pending_results.insert(pending_results.size(), pred);
  endtask

  // Mostly well-formed traffic: rising stamps per buffer, lookups near stored times
  task automatic random_op();
    int unsigned        pick;
    int unsigned        k;
    int unsigned        b;
    int unsigned        n;
    logic [STAMP_W-1:0] head;
    logic [STAMP_W-1:0] t;
    logic [STAMP_W:0]   sum;
    logic [OP_W-1:0]    op;
    b = $urandom_range(BUFFERS - 1);
    n = frames_held[b];
    head = (n > 0) ? stamp_mem[b][n-1] : '0;
    pick = $urandom_range(99);
    k = $urandom_range(99);
    t = $urandom;
    if (pick < 55) begin
      op = OP_APPEND;
      if (n > 0 && (n > 40 || k < 12)) begin
        t = stamp_mem[b][$urandom_range(n - 1)];
      end else if (k >= 20) begin
        sum = head + $urandom_range(1, 'h30000);
        t = sum[STAMP_W] ? STAMP_W'($urandom) : sum[STAMP_W-1:0];
      end
    end else if (pick < 93) begin
      op = OP_LOOKUP;
      if (n > 0 && k < 80)
        t = stamp_mem[b][$urandom_range(n - 1)] + $urandom_range('h20000) - 'h10000;
    end else if (pick < 95) begin
      op = OP_CLEAR;
    end else begin
      op = OP_UNUSED;
    end
    issue_op(op, SEL_W'(b), t, {$urandom, $urandom});
  endtask

  task automatic test_directed_cases();
    issue_op(OP_LOOKUP, 2'd0, 32'h0001_0000, '0);
    issue_op(OP_APPEND, 2'd0, 32'h0001_0000, '0);
    issue_op(OP_LOOKUP, 2'd0, 32'h0001_0000, '0);
    issue_op(OP_APPEND, 2'd0, 32'h0002_0000, '1);
    issue_op(OP_APPEND, 2'd0, 32'h0003_0000, 64'hA5A5_5A5A_F0F0_0F0F);
    issue_op(OP_APPEND, 2'd0, 32'h0004_8000, {$urandom, $urandom});
    issue_op(OP_LOOKUP, 2'd0, 32'h0000_0000, '0);   // before first frame
    issue_op(OP_LOOKUP, 2'd0, 32'h0002_8000, '0);
    issue_op(OP_LOOKUP, 2'd0, 32'h0003_0000, '0);
    issue_op(OP_LOOKUP, 2'd0, 32'hFFFF_FFFF, '0);   // past the end
    issue_op(OP_LOOKUP, 2'd0, 32'h0001_0000, '0);   // walk back
    issue_op(OP_APPEND, 2'd0, 32'h0003_0000, '1);   // equal stamp supersedes
    issue_op(OP_APPEND, 2'd0, 32'h0001_8000, '0);   // drops several
    issue_op(OP_APPEND, 2'd1, 32'hFFFF_FFFF, '1);
    issue_op(OP_APPEND, 2'd1, 32'h0000_0000, 64'h1);
    issue_op(OP_APPEND, 2'd1, 32'h0000_0001, 64'h8000_0000_0000_0000);
    issue_op(OP_LOOKUP, 2'd1, 32'h0000_0000, '0);
    issue_op(OP_UNUSED, 2'd0, 32'h0001_8000, '1);
    issue_op(OP_APPEND, 2'd3, 32'h1234_5678, {$urandom, $urandom});
    issue_op(OP_LOOKUP, 2'd3, 32'h1234_5678, '0);   // single frame
    issue_op(OP_APPEND, 2'd2, 32'h0000_0100, '0);
    issue_op(OP_LOOKUP, 2'd2, 32'h0000_0100, '0);
    issue_op(OP_CLEAR,  2'd1, 32'h0, '0);
    issue_op(OP_LOOKUP, 2'd0, 32'h0001_0000, '0);
    issue_op(OP_APPEND, 2'd0, 32'h0000_0005, '1);
  endtask

  task automatic test_full_buffer();
    for (int i = 1; i <= DEPTH; i++)
      issue_op(OP_APPEND, 2'd2, STAMP_W'(i) << 8, {$urandom, $urandom});
    issue_op(OP_APPEND, 2'd2, STAMP_W'(DEPTH + 1) << 8, '1);   // refused
    issue_op(OP_LOOKUP, 2'd2, STAMP_W'(DEPTH / 2) << 8, '0);
    issue_op(OP_LOOKUP, 2'd2, 32'hFFFF_FFFF, '0);
    issue_op(OP_LOOKUP, 2'd2, 32'h0000_0100, '0);
    issue_op(OP_APPEND, 2'd2, STAMP_W'(DEPTH) << 8, '0);       // full, one dropped
    issue_op(OP_APPEND, 2'd2, 32'h0000_0300, '1);              // long truncation
    issue_op(OP_LOOKUP, 2'd2, 32'h0000_0280, '0);
    issue_op(OP_CLEAR,  2'd2, 32'h0, '0);
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) random_op();
  endtask

  task automatic test_no_idle_traffic(input int count);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (count) random_op();
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_output_holdoff(input int count);
    hold_cycles = HOLD_CYCLES;
    repeat (count) random_op();
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles--;
    end else begin
      out_stall <= sink_idle_en && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transaction with none expected", $time);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ok !== want.ok) begin
          $display("%0t: ok expected %0b actual %0b", $time, want.ok, out_ok);
          err_count++;
        end
        if (out_not_ended !== want.not_ended) begin
          $display("%0t: not_ended expected %0b actual %0b", $time, want.not_ended,
                   out_not_ended);
          err_count++;
        end
        if (out_payload_out !== want.payload_out) begin
          $display("%0t: payload_out expected %h actual %h", $time, want.payload_out,
                   out_payload_out);
          err_count++;
        end
        if (out_last_stamp !== want.last_stamp) begin
          $display("%0t: last_stamp expected %h actual %h", $time, want.last_stamp,
                   out_last_stamp);
          err_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_full_buffer();
    test_random_traffic(550);
    test_no_idle_traffic(200);
    test_output_holdoff(100);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
